// ===== hw/rtl/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer / unmasker.
// Used by websocket_frame_deframer_unmask_top; no dependencies.
package wsdf_pkg;

    localparam int LENGTH_WIDTH_DEF = 64;

    // 7-bit length codes that select an extended length field
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // remaining-byte counts (minus one) for each header part
    localparam logic [2:0] CNT_EXT16 = 3'd1;
    localparam logic [2:0] CNT_EXT64 = 3'd7;
    localparam logic [2:0] CNT_KEY   = 3'd3;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_DONE = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

endpackage

// ===== hw/rtl/websocket_frame_deframer_unmask_top.sv =====
// WebSocket frame deframer: header parse, length decode and payload unmasking.
// Path: input register, then result register; one byte per clock unless stalled.
// Parser state and result register update in one pass.
// Reset (i_rst_n, synchronous, active low) clears both valid flags and the parser
// state; the next byte is taken as the first header byte of a frame.
// Depends on wsdf_pkg.
module websocket_frame_deframer_unmask_top #(
    parameter int LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [3:0]  o_opcode,
    output logic        o_fin,
    output logic        o_masked,
    output logic [63:0] o_payload_length,
    output logic        o_last
);

    localparam int LW = LENGTH_WIDTH;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    wsdf_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_count, n_count;
    logic [7:0]       r_first, n_first;
    logic             r_maskp, n_maskp;
    logic [LW-1:0]    r_len,   n_len;
    logic [31:0]      r_key,   n_key;
    logic [LW-1:0]    r_left,  n_left;
    logic [1:0]       r_idx,   n_idx;

    // result register
    logic             r_out_valid;
    wsdf_pkg::t_kind  r_kind,  n_kind;
    logic [7:0]       r_obyte, n_obyte;
    logic             r_info,  n_info;
    logic             r_last,  n_last;
    logic [3:0]       r_opc;
    logic             r_fin;
    logic             r_omask;
    logic [LW-1:0]    r_olen;

    logic          adv;
    logic          fire;
    logic [6:0]    code;
    logic [LW-1:0] ext_len;
    logic [7:0]    key_byte;
    logic          hdr_done;

    assign adv     = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;

    assign code = r_in_byte[6:0];

    // shift one big-endian length byte in, saturating when it would overflow
    always_comb begin
        if (r_len[LW-1 -: 8] != 8'd0) begin
            ext_len = '1;
        end else begin
            ext_len = {r_len[LW-9:0], r_in_byte};
        end
    end

    always_comb begin
        unique case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // next-state logic
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_first  = r_first;
        n_maskp  = r_maskp;
        n_len    = r_len;
        n_key    = r_key;
        n_left   = r_left;
        n_idx    = r_idx;
        hdr_done = 1'b0;
        unique case (r_phase)
            wsdf_pkg::PH_SECOND: begin
                n_maskp = r_in_byte[7];
                if (code < wsdf_pkg::LEN_CODE_EXT16) begin
                    n_len = LW'(code);
                    if (r_in_byte[7]) begin
                        n_phase = wsdf_pkg::PH_KEY;
                        n_count = wsdf_pkg::CNT_KEY;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end else begin
                    n_len   = '0;
                    n_phase = wsdf_pkg::PH_EXTLEN;
                    n_count = (code == wsdf_pkg::LEN_CODE_EXT16) ? wsdf_pkg::CNT_EXT16
                                                                  : wsdf_pkg::CNT_EXT64;
                end
            end
            wsdf_pkg::PH_EXTLEN: begin
                n_len = ext_len;
                if (r_count == 3'd0) begin
                    if (r_maskp) begin
                        n_phase = wsdf_pkg::PH_KEY;
                        n_count = wsdf_pkg::CNT_KEY;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end else begin
                    n_count = r_count - 3'd1;
                end
            end
            wsdf_pkg::PH_KEY: begin
                n_key = {r_key[23:0], r_in_byte};
                if (r_count == 3'd0) begin
                    hdr_done = 1'b1;
                end else begin
                    n_count = r_count - 3'd1;
                end
            end
            wsdf_pkg::PH_PAYLOAD: begin
                n_idx = r_idx + 2'd1;
                if (r_left != '0) begin
                    n_left = r_left - LW'(1);
                end
                if (n_left == '0) begin
                    n_phase = wsdf_pkg::PH_FIRST;
                end
            end
            default: begin
                n_first = r_in_byte;
                n_key   = '0;
                n_count = '0;
                n_phase = wsdf_pkg::PH_SECOND;
            end
        endcase
        if (hdr_done) begin
            n_idx   = '0;
            n_left  = n_len;
            n_phase = (n_len == '0) ? wsdf_pkg::PH_FIRST : wsdf_pkg::PH_PAYLOAD;
        end
    end

    // result logic
    always_comb begin
        n_obyte = r_in_byte;
        if (r_phase == wsdf_pkg::PH_PAYLOAD) begin
            n_kind  = wsdf_pkg::KIND_DATA;
            n_info  = 1'b1;
            n_last  = (n_left == '0);
            if (r_maskp) begin
                n_obyte = r_in_byte ^ key_byte;
            end
        end else if (hdr_done) begin
            n_kind = wsdf_pkg::KIND_DONE;
            n_info = 1'b1;
            n_last = (n_len == '0);
        end else begin
            n_kind = wsdf_pkg::KIND_HDR;
            n_info = 1'b0;
            n_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= wsdf_pkg::PH_FIRST;
            r_count     <= '0;
            r_first     <= '0;
            r_maskp     <= 1'b0;
            r_len       <= '0;
            r_key       <= '0;
            r_left      <= '0;
            r_idx       <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_first <= n_first;
                r_maskp <= n_maskp;
                r_len   <= n_len;
                r_key   <= n_key;
                r_left  <= n_left;
                r_idx   <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (fire) begin
            r_kind  <= n_kind;
            r_obyte <= n_obyte;
            r_info  <= n_info;
            r_last  <= n_last;
            r_opc   <= n_first[3:0];
            r_fin   <= n_first[7];
            r_omask <= n_maskp;
            r_olen  <= n_len;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_out_byte       = r_obyte;
    assign o_opcode         = r_info ? r_opc : 4'd0;
    assign o_fin            = r_info & r_fin;
    assign o_masked         = r_info & r_omask;
    assign o_payload_length = r_info ? 64'(r_olen) : 64'd0;
    assign o_last           = r_last;

    // header-byte transactions carry no frame info
    a_hdr_no_info: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wsdf_pkg::KIND_HDR) |-> (o_payload_length == 64'd0 && !o_last))
        else $error("header byte result carries frame info");

    // a payload byte processed always yields a payload result
    a_payload_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_phase == wsdf_pkg::PH_PAYLOAD) |=> (o_valid && o_kind == wsdf_pkg::KIND_DATA))
        else $error("payload byte did not give a payload result");

    // after the last payload byte the parser waits for a new frame
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wsdf_pkg::KIND_DATA && o_last) |-> r_phase == wsdf_pkg::PH_FIRST)
        else $error("frame end without return to first header byte");

    // key phase never counts past four bytes
    a_key_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsdf_pkg::PH_KEY) |-> (r_count <= wsdf_pkg::CNT_KEY))
        else $error("key byte count out of range");

endmodule

// ===== dv/websocket_frame_deframer_unmask_top_tb.sv =====
// Self-checking testbench for websocket_frame_deframer_unmask_top: a directed frame table,
// random frames with random handshake gaps and a maximum-length frame, checked against
// hand-written rows or a local frame parser. Depends on wsdf_pkg and the top-level RTL.
`timescale 1ns / 100ps

module websocket_frame_deframer_unmask_top_tb;

    localparam int LEN_W = 64;
    localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_W);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD = 64;

    // length encodings used when building frames
    localparam int ENC_SHORT = 0;
    localparam int ENC_EXT16 = 1;
    localparam int ENC_EXT64 = 2;

    typedef struct packed {
        wsdf_pkg::t_kind kind;
        logic [7:0]      data;
        logic [3:0]      opcode;
        logic            fin;
        logic            masked;
        logic [63:0]     length;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;   // res holds a hand-written expectation
        t_result    res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [3:0]  o_opcode;
    logic        o_fin;
    logic        o_masked;
    logic [63:0] o_payload_length;
    logic        o_last;

    websocket_frame_deframer_unmask_top #(
        .LENGTH_WIDTH(LEN_W)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data_byte(i_data_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_kind(o_kind),
        .o_out_byte(o_out_byte),
        .o_opcode(o_opcode),
        .o_fin(o_fin),
        .o_masked(o_masked),
        .o_payload_length(o_payload_length),
        .o_last(o_last)
    );

    // parser state mirrored by the predictor
    wsdf_pkg::t_phase parse_phase;
    logic [2:0]       hdr_left;
    logic [7:0]       frame_hdr0;
    logic             frame_masked;
    logic [63:0]      frame_len;
    logic [31:0]      unmask_key;
    logic [63:0]      payload_left;
    logic [1:0]       key_pos;

    t_stim_row byte_stream[$];
    t_result   pending_results[$];
    t_stim_row dir_table[24];

    bit tx_burst;
    int n_sent;
    int mismatches;
    int idle_cycles;
    int n_frames;
    int n_payload;
    int n_masked;
    int n_results;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_stim_row raw_byte(logic [7:0] b);
        t_stim_row row;
        row = '0;
        row.data = b;
        return row;
    endfunction

    // header byte that is only consumed: all frame fields read zero
    function automatic t_stim_row consumed(logic [7:0] b);
        t_stim_row row;
        row = '0;
        row.data = b;
        row.typed = 1'b1;
        row.res.kind = wsdf_pkg::KIND_HDR;
        row.res.data = b;
        return row;
    endfunction

    function automatic t_stim_row framed(logic [7:0] b, wsdf_pkg::t_kind k, logic [7:0] ob,
                                         logic [3:0] opc, logic fn, logic msk,
                                         logic [63:0] len, logic lst);
        t_stim_row row;
        row.data = b;
        row.typed = 1'b1;
        row.res = '{kind: k, data: ob, opcode: opc, fin: fn, masked: msk,
                    length: len, last: lst};
        return row;
    endfunction

    // one byte through the frame parser
    task automatic deframe_step(input logic [7:0] b, output t_result r);
        logic [6:0] code;
        bit         len_end;
        bit         hdr_end;
        len_end = 1'b0;
        hdr_end = 1'b0;
        r = '0;
        r.kind = wsdf_pkg::KIND_HDR;
        r.data = b;
        case (parse_phase)
            wsdf_pkg::PH_SECOND: begin
                code = b[6:0];
                frame_masked = b[7];
                frame_len = '0;
                if (code < wsdf_pkg::LEN_CODE_EXT16) begin
                    frame_len = 64'(code);
                    len_end = 1'b1;
                end else begin
                    hdr_left = (code == wsdf_pkg::LEN_CODE_EXT16) ? wsdf_pkg::CNT_EXT16
                                                                   : wsdf_pkg::CNT_EXT64;
                    parse_phase = wsdf_pkg::PH_EXTLEN;
                end
            end
            wsdf_pkg::PH_EXTLEN: begin
                // saturate once the next shift would overflow the length width
                if (frame_len > (LEN_MAX >> 8))
                    frame_len = LEN_MAX;
                else
                    frame_len = (frame_len << 8) | 64'(b);
                if (frame_len > LEN_MAX)
                    frame_len = LEN_MAX;
                if (hdr_left == 3'd0)
                    len_end = 1'b1;
                else
                    hdr_left = hdr_left - 3'd1;
            end
            wsdf_pkg::PH_KEY: begin
                unmask_key = {unmask_key[23:0], b};
                if (hdr_left == 3'd0)
                    hdr_end = 1'b1;
                else
                    hdr_left = hdr_left - 3'd1;
            end
            wsdf_pkg::PH_PAYLOAD: begin
                r.kind = wsdf_pkg::KIND_DATA;
                r.data = frame_masked ? (b ^ unmask_key[8 * (3 - key_pos) +: 8]) : b;
                key_pos = key_pos + 2'd1;
                if (payload_left != 0)
                    payload_left = payload_left - 64'd1;
                r.last = (payload_left == 0);
                if (r.last)
                    parse_phase = wsdf_pkg::PH_FIRST;
            end
            default: begin
                frame_hdr0 = b;
                unmask_key = '0;
                hdr_left = '0;
                parse_phase = wsdf_pkg::PH_SECOND;
            end
        endcase
        if (len_end) begin
            if (frame_masked) begin
                parse_phase = wsdf_pkg::PH_KEY;
                hdr_left = wsdf_pkg::CNT_KEY;
            end else begin
                hdr_end = 1'b1;
            end
        end
        if (hdr_end) begin
            key_pos = '0;
            payload_left = frame_len;
            parse_phase = (frame_len == 0) ? wsdf_pkg::PH_FIRST : wsdf_pkg::PH_PAYLOAD;
            r.kind = wsdf_pkg::KIND_DONE;
            r.last = (frame_len == 0);
        end
        if (r.kind != wsdf_pkg::KIND_HDR) begin
            r.opcode = frame_hdr0[3:0];
            r.fin = frame_hdr0[7];
            r.masked = frame_masked;
            r.length = frame_len;
        end
    endtask

    task automatic queue_frame(input logic [7:0] hdr0, input logic msk,
                               input logic [63:0] len, input int enc, input int n_bytes);
        logic [31:0] mkey;
        mkey = $urandom;
        byte_stream.push_back(raw_byte(hdr0));
        if (enc == ENC_SHORT) begin
            byte_stream.push_back(raw_byte({msk, len[6:0]}));
        end else if (enc == ENC_EXT16) begin
            byte_stream.push_back(raw_byte({msk, wsdf_pkg::LEN_CODE_EXT16}));
            byte_stream.push_back(raw_byte(len[15:8]));
            byte_stream.push_back(raw_byte(len[7:0]));
        end else begin
            byte_stream.push_back(raw_byte({msk, wsdf_pkg::LEN_CODE_EXT64}));
            for (int i = 7; i >= 0; i--)
                byte_stream.push_back(raw_byte(len[8 * i +: 8]));
        end
        if (msk) begin
            for (int i = 3; i >= 0; i--)
                byte_stream.push_back(raw_byte(mkey[8 * i +: 8]));
        end
        repeat (n_bytes) byte_stream.push_back(raw_byte(8'($urandom)));
    endtask

    // well-formed frames with random header bits, keys and payload; mostly short,
    // with non-minimal extended encodings mixed in
    task automatic build_random(input int n_items);
        int          sel;
        int          enc;
        logic [63:0] len;
        while (byte_stream.size() < n_items) begin
            sel = $urandom_range(0, 99);
            enc = ENC_SHORT;
            if (sel < 60) begin
                len = 64'($urandom_range(0, 20));
            end else if (sel < 75) begin
                len = 64'($urandom_range(0, 125));
            end else if (sel < 90) begin
                enc = ENC_EXT16;
                if ($urandom_range(0, 3) == 0)
                    len = 64'($urandom_range(126, 400));
                else
                    len = 64'($urandom_range(0, 30));
            end else begin
                enc = ENC_EXT64;
                len = 64'($urandom_range(0, 30));
            end
            queue_frame(8'($urandom), logic'($urandom_range(0, 3) != 0), len, enc, int'(len));
        end
    endtask

    task automatic send_stream();
        t_stim_row row;
        t_result   r;
        int        gap;
        while (byte_stream.size() > 0) begin
            row = byte_stream.pop_front();
            if (n_sent % 128 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            gap = tx_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data_byte <= row.data;
            do @(posedge i_clk); while (o_stall);
            deframe_step(row.data, r);
            pending_results.push_back(row.typed ? row.res : r);
            n_sent++;
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // result side: random stalls, one long hold after 500 results have been taken
    initial begin
        int gap;
        int n_taken;
        bit rx_burst;
        bit held;
        n_taken = 0;
        rx_burst = 1'b0;
        held = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (n_taken % 150 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 7);
            if (!held && n_taken >= 500) begin
                gap = LONG_HOLD;
                held = 1'b1;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            n_taken++;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
            if (o_valid && !i_stall) begin
                n_results++;
                if (o_kind == wsdf_pkg::KIND_DONE) begin
                    n_frames++;
                    if (o_masked) n_masked++;
                end
                if (o_kind == wsdf_pkg::KIND_DATA) n_payload++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", n_results);
                end else begin
                    want = pending_results.pop_front();
                    if (o_kind !== want.kind || o_out_byte !== want.data
                        || o_opcode !== want.opcode || o_fin !== want.fin
                        || o_masked !== want.masked || o_payload_length !== want.length
                        || o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d exp kind=%0d byte=%02h op=%h fin=%b",
                                     n_results, want.kind, want.data, want.opcode, want.fin);
                            $display("    exp m=%b len=%0h last=%b",
                                     want.masked, want.length, want.last);
                            $display("result %0d got kind=%0d byte=%02h op=%h fin=%b",
                                     n_results, o_kind, o_out_byte, o_opcode, o_fin);
                            $display("    got m=%b len=%0h last=%b",
                                     o_masked, o_payload_length, o_last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data_byte <= 8'h00;
        parse_phase = wsdf_pkg::PH_FIRST;
        hdr_left = '0;
        frame_hdr0 = '0;
        frame_masked = 1'b0;
        frame_len = '0;
        unmask_key = '0;
        payload_left = '0;
        key_pos = '0;
        tx_burst = 1'b0;
        n_sent = 0;
        mismatches = 0;
        idle_cycles = 0;
        n_frames = 0;
        n_payload = 0;
        n_masked = 0;
        n_results = 0;

        // unmasked empty ping
        dir_table[0] = consumed(8'h89);
        dir_table[1] = framed(8'h00, wsdf_pkg::KIND_DONE, 8'h00, 4'h9, 1'b1, 1'b0, 64'd0,
                              1'b1);
        // masked, 16-bit length of 3, key FF 00 A5 5A
        dir_table[2] = consumed(8'h0F);
        dir_table[3] = consumed(8'hFE);
        dir_table[4] = consumed(8'h00);
        dir_table[5] = consumed(8'h03);
        dir_table[6] = consumed(8'hFF);
        dir_table[7] = consumed(8'h00);
        dir_table[8] = consumed(8'hA5);
        dir_table[9] = framed(8'h5A, wsdf_pkg::KIND_DONE, 8'h5A, 4'hF, 1'b0, 1'b1, 64'd3,
                              1'b0);
        dir_table[10] = raw_byte(8'h00);
        dir_table[11] = raw_byte(8'hFF);
        dir_table[12] = raw_byte(8'h5A);
        // RSV bits set, unmasked, 64-bit length of 1
        dir_table[13] = consumed(8'h72);
        dir_table[14] = consumed(8'h7F);
        for (int i = 15; i < 22; i++)
            dir_table[i] = consumed(8'h00);
        dir_table[22] = framed(8'h01, wsdf_pkg::KIND_DONE, 8'h01, 4'h2, 1'b0, 1'b0, 64'd1,
                               1'b0);
        dir_table[23] = framed(8'hC3, wsdf_pkg::KIND_DATA, 8'hC3, 4'h2, 1'b0, 1'b0, 64'd1,
                               1'b1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i])
            byte_stream.push_back(dir_table[i]);
        send_stream();
        wait_drained();

        build_random(900);
        send_stream();
        wait_drained();

        build_random(900);
        send_stream();
        wait_drained();

        // maximum 64-bit length; this frame never ends, so it goes last
        queue_frame(8'h82, 1'b0, LEN_MAX, ENC_EXT64, 6);
        send_stream();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end
        $display("%0d bytes in, %0d results: %0d headers (%0d masked), %0d payload bytes",
                 n_sent, n_results, n_frames, n_masked, n_payload);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
